// ===== design/wsfr_pkg.sv =====
// Package for the frame receiver: opcode, length and event codes, result record type, queue depth.
// No dependencies.
`default_nettype none
package wsfr_pkg;
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_TEXT   = 3'd1,
		EV_PING   = 3'd2,
		EV_PONG   = 3'd3,
		EV_CLOSE  = 3'd4,
		EV_MASKED = 3'd5,
		EV_BINARY = 3'd6,
		EV_STRAY  = 3'd7
	} event_t;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Result record passed from parser to output queue.
	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		event_t     event_res;
		logic [15:0] close_code;
	} result_t;

	localparam int QDEPTH = 2;
	localparam int QAW = 1;
endpackage
`default_nettype wire

// ===== design/wsfr_parser.sv =====
// Front part: byte-wide frame parser producing at most one result per byte.
// Depends on wsfr_pkg.
`default_nettype none
module wsfr_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_take,
	input  wire logic [7:0]       in_byte,
	output logic                  res_push,
	output wsfr_pkg::result_t     res
);
	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0, PH_HDR1 = 3'd1, PH_EXTLEN = 3'd2,
		PH_MASKKEY = 3'd3, PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  cnt_q;
	logic        fin_q, mask_q, frag_q;
	logic [3:0]  op_q, msg_q;
	logic [31:0] rem_q;
	logic [15:0] acc_q;
	logic [1:0]  pidx_q;

	// next-state values
	phase_t      phase_d;
	logic [2:0]  cnt_d;
	logic        fin_d, mask_d, frag_d;
	logic [3:0]  op_d, msg_d;
	logic [31:0] rem_d;
	logic [15:0] acc_d;
	logic [1:0]  pidx_d;
	logic        fin_now, has_byte, em, emit_pl;
	logic [3:0]  eff_op;
	logic [31:0] rem_dec;
	wsfr_pkg::event_t ev;
	logic [15:0] code;

	assign eff_op  = (op_q == wsfr_pkg::OP_CONT && msg_q != 4'd0) ? msg_q : op_q;
	assign rem_dec = rem_q - 32'd1;

	// Decode one byte
	always_comb begin
		phase_d = phase_q; cnt_d = cnt_q; fin_d = fin_q; mask_d = mask_q;
		frag_d = frag_q; op_d = op_q; msg_d = msg_q; rem_d = rem_q;
		acc_d = acc_q; pidx_d = pidx_q;
		fin_now = 1'b0; has_byte = 1'b0; emit_pl = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				mask_d = in_byte[7];
				rem_d = 32'd0;
				if (in_byte[6:0] == wsfr_pkg::LEN_EXT16) begin
					phase_d = PH_EXTLEN; cnt_d = 3'd1;
				end else if (in_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
					phase_d = PH_EXTLEN; cnt_d = 3'd7;
				end else begin
					rem_d = {25'd0, in_byte[6:0]};
					if (in_byte[7]) begin
						phase_d = PH_MASKKEY; cnt_d = 3'd3;
					end else if (in_byte[6:0] == 7'd0) fin_now = 1'b1;
					else phase_d = PH_PAYLOAD;
				end
			end
			PH_EXTLEN: begin
				rem_d = {rem_q[23:0], in_byte};
				if (cnt_q == 3'd0) begin
					if (mask_q) begin
						phase_d = PH_MASKKEY; cnt_d = 3'd3;
					end else if (rem_d == 32'd0) fin_now = 1'b1;
					else phase_d = PH_PAYLOAD;
				end else cnt_d = cnt_q - 3'd1;
			end
			PH_MASKKEY: begin
				if (cnt_q == 3'd0) begin
					if (rem_q == 32'd0) fin_now = 1'b1;
					else phase_d = PH_PAYLOAD;
				end else cnt_d = cnt_q - 3'd1;
			end
			PH_PAYLOAD: begin
				if (!pidx_q[1]) begin
					acc_d = {acc_q[7:0], in_byte};
					pidx_d = pidx_q + 2'd1;
				end
				rem_d = rem_dec;
				if (rem_dec == 32'd0) begin
					fin_now = 1'b1; has_byte = 1'b1;
				end else emit_pl = !mask_q;
			end
			default: begin
				fin_d = in_byte[7];
				op_d = in_byte[3:0];
				acc_d = 16'd0; pidx_d = 2'd0; cnt_d = 3'd0;
				phase_d = PH_HDR1;
			end
		endcase

		// frame end bookkeeping, using the mask bit of the current frame
		ev = wsfr_pkg::EV_NONE; code = 16'd0;
		if (fin_now) begin
			phase_d = PH_HDR0;
			if (mask_d) ev = wsfr_pkg::EV_MASKED;
			else if (!fin_q) begin
				if (!frag_q) begin
					frag_d = 1'b1; msg_d = op_q;
				end
			end else begin
				if (op_q == wsfr_pkg::OP_CONT && msg_q != 4'd0) msg_d = 4'd0;
				frag_d = 1'b0;
				unique case (eff_op)
					wsfr_pkg::OP_CONT:   ev = wsfr_pkg::EV_STRAY;
					wsfr_pkg::OP_TEXT:   ev = wsfr_pkg::EV_TEXT;
					wsfr_pkg::OP_BINARY: ev = wsfr_pkg::EV_BINARY;
					wsfr_pkg::OP_PING:   ev = wsfr_pkg::EV_PING;
					wsfr_pkg::OP_PONG:   ev = wsfr_pkg::EV_PONG;
					wsfr_pkg::OP_CLOSE: begin
						ev = wsfr_pkg::EV_CLOSE;
						code = pidx_d[1] ? acc_d : 16'd0;
					end
					default: ev = wsfr_pkg::EV_NONE;
				endcase
			end
		end

		em = emit_pl || (fin_now && (ev != wsfr_pkg::EV_NONE || (has_byte && !mask_d)));
		res.payload_valid = emit_pl || (has_byte && !mask_d);
		res.payload_byte  = res.payload_valid ? in_byte : 8'd0;
		res.frame_opcode  = (fin_now && mask_d) ? op_q : eff_op;
		res.event_res     = ev;
		res.close_code    = code;
		res_push          = in_take && em;
	end

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0; cnt_q <= 3'd0; fin_q <= 1'b0; mask_q <= 1'b0;
			frag_q <= 1'b0; op_q <= 4'd0; msg_q <= 4'd0; rem_q <= 32'd0;
			acc_q <= 16'd0; pidx_q <= 2'd0;
		end else if (in_take) begin
			phase_q <= phase_d; cnt_q <= cnt_d; fin_q <= fin_d; mask_q <= mask_d;
			frag_q <= frag_d; op_q <= op_d; msg_q <= msg_d; rem_q <= rem_d;
			acc_q <= acc_d; pidx_q <= pidx_d;
		end
	end

	// Masked payload never reaches the output
	a_mask_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && mask_q && phase_q == PH_PAYLOAD) |-> !res.payload_valid)
		else $error("masked payload passed");
	a_close_code: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.event_res != wsfr_pkg::EV_CLOSE) |-> res.close_code == 16'd0)
		else $error("close code on non-close event");
	a_len_used: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && phase_q == PH_PAYLOAD) |-> rem_q != 32'd0)
		else $error("payload with zero remaining length");
endmodule
`default_nettype wire

// ===== design/wsfr_queue.sv =====
// Back part: small result queue decoupling the parser from the consumer.
// Depends on wsfr_pkg.
`default_nettype none
module wsfr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire wsfr_pkg::result_t wdata,
	input  wire logic              rd,
	output logic                   q_full,
	output logic                   q_empty,
	output wsfr_pkg::result_t      rdata
);
	wsfr_pkg::result_t mem_q [wsfr_pkg::QDEPTH];
	logic [wsfr_pkg::QAW-1:0] wp_q, rp_q;
	logic [wsfr_pkg::QAW:0]   cnt_q;
	logic do_wr, do_rd;

	assign q_full  = (cnt_q == wsfr_pkg::QAW'(0) + (wsfr_pkg::QAW+1)'(wsfr_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rp_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (wsfr_pkg::QAW+1)'(do_wr) - (wsfr_pkg::QAW+1)'(do_rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= (wsfr_pkg::QAW+1)'(wsfr_pkg::QDEPTH)))
		else $error("queue count out of range");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count slip");
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty && !wr) |=> q_empty)
		else $error("queue filled without write");
endmodule
`default_nettype wire

// ===== design/websocket_frame_receiver.sv =====
// Top level: frame parser feeding a two-entry result queue.
// Depends on wsfr_pkg, wsfr_parser, wsfr_queue.
//   channel | handshake   | payload
//   input   | push / full | rx_byte
//   result  | empty / pop | payload_valid payload_byte frame_opcode event_res close_code
// One byte is parsed per cycle while full is low; a byte enters the cycle it is pushed unless full is high.
// A result is queued with its byte and reaches the outputs once it heads the queue; the two-entry queue sets the slack.
// full rises only when the queue is full; then input stalls until a pop.
// arst_n clears parse state and empties the queue.
`default_nettype none
module websocket_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic             payload_valid,
	output logic [7:0]       payload_byte,
	output logic [3:0]       frame_opcode,
	output logic [2:0]       event_res,
	output logic [15:0]      close_code
);
	logic take, res_push, q_full;
	wsfr_pkg::result_t res, head;

	assign full = q_full;
	assign take = push && !q_full;

	wsfr_parser u_parser (
		.clk(clk), .arst_n(arst_n), .in_take(take), .in_byte(rx_byte),
		.res_push(res_push), .res(res)
	);

	wsfr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(res_push), .wdata(res), .rd(pop),
		.q_full(q_full), .q_empty(empty), .rdata(head)
	);

	assign payload_valid = head.payload_valid;
	assign payload_byte  = head.payload_byte;
	assign frame_opcode  = head.frame_opcode;
	assign event_res     = head.event_res;
	assign close_code    = head.close_code;
endmodule
`default_nettype wire
